### rtl/pva_pkg.sv
// Shared constants, types and codes for the voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int unsigned VOICE_COUNT = 13;
  localparam int unsigned VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned NOTE_W  = 4;
  localparam int unsigned VOICE_W = 4;
  localparam int unsigned MASK_W  = 13;
  localparam int unsigned STAT_W  = 8;
  localparam int unsigned KEY_W   = 7;
  localparam int unsigned VEL_W   = 7;

  // voices that actually show up in the masks
  localparam int unsigned MASK_USED = (VOICE_COUNT < MASK_W) ? VOICE_COUNT : MASK_W;

  typedef logic [VIDX_W-1:0]      vidx_t;
  typedef logic [NOTE_W-1:0]      note_t;
  typedef logic [MASK_W-1:0]      mask_t;
  typedef logic [VOICE_COUNT-1:0] vvec_t;
  typedef logic [VOICE_W-1:0]     voice_t;
  typedef logic [KEY_W-1:0]       key_t;

  localparam note_t NOTE_LIMIT = 4'd13;
  localparam note_t NO_NOTE    = 4'd15;

  localparam logic [STAT_W-1:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [STAT_W-1:0] MIDI_NOTE_OFF = 8'h80;
  localparam logic [VEL_W-1:0]  MIDI_VEL_ON   = 7'd127;
  localparam key_t              MIDI_TOP_KEY  = 7'd72;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_NOTE_ON  = 2'd0,
    FUNC_NOTE_OFF = 2'd1,
    FUNC_VOICE_FIN = 2'd2
  } func_e;

  // one update of the voice file per cycle
  typedef struct packed {
    logic  claim;     // set active and gate, store note
    logic  free;      // clear active and gate, note back to none
    logic  gate_clr;  // drop gate only
    vidx_t idx;
    note_t note;
  } vf_cmd_t;

  typedef struct packed {
    vvec_t active;
    vvec_t gate;
    note_t rd_note;   // note of voice at cmd.idx
  } vf_stat_t;

endpackage

### rtl/pva_in_if.sv
// Event word channel into the voice allocator.
`timescale 1ns / 1ps

interface pva_in_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::FUNC_W-1:0]  func;
  logic [pva_pkg::NOTE_W-1:0]  note_index;
  logic [pva_pkg::VOICE_W-1:0] finished_voice;

  modport source (output valid, output func, output note_index, output finished_voice,
                  input ready);
  modport sink   (input valid, input func, input note_index, input finished_voice,
                  output ready);
endinterface

### rtl/pva_out_if.sv
// Result word channel out of the voice allocator.
`timescale 1ns / 1ps

interface pva_out_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::VOICE_W-1:0] chosen_voice;
  logic                        stolen;
  logic [pva_pkg::MASK_W-1:0]  gate_mask;
  logic [pva_pkg::MASK_W-1:0]  active_mask;
  logic                        midi_valid;
  logic [pva_pkg::STAT_W-1:0]  midi_status;
  logic [pva_pkg::KEY_W-1:0]   midi_key;
  logic [pva_pkg::VEL_W-1:0]   midi_velocity;

  modport source (output valid, output chosen_voice, output stolen, output gate_mask,
                  output active_mask, output midi_valid, output midi_status,
                  output midi_key, output midi_velocity, input ready);
  modport sink   (input valid, input chosen_voice, input stolen, input gate_mask,
                  input active_mask, input midi_valid, input midi_status,
                  input midi_key, input midi_velocity, output ready);
endinterface

### rtl/pva_voice_file.sv
// Per-voice state: active and gate bits, stored note, one update per cycle.
`timescale 1ns / 1ps

module pva_voice_file (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pva_pkg::vf_cmd_t  cmd_i,
  output pva_pkg::vf_stat_t stat_o
);

  pva_pkg::vvec_t active_q, active_d;
  pva_pkg::vvec_t gate_q, gate_d;
  pva_pkg::note_t note_q [pva_pkg::VOICE_COUNT];

  always_comb begin
    active_d = active_q;
    gate_d   = gate_q;
    if (cmd_i.claim) begin
      active_d[cmd_i.idx] = 1'b1;
      gate_d[cmd_i.idx]   = 1'b1;
    end else if (cmd_i.free) begin
      active_d[cmd_i.idx] = 1'b0;
      gate_d[cmd_i.idx]   = 1'b0;
    end else if (cmd_i.gate_clr) begin
      gate_d[cmd_i.idx]   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      gate_q   <= '0;
      for (int i = 0; i < pva_pkg::VOICE_COUNT; i++) begin
        note_q[i] <= pva_pkg::NO_NOTE;
      end
    end else begin
      active_q <= active_d;
      gate_q   <= gate_d;
      if (cmd_i.claim) begin
        note_q[cmd_i.idx] <= cmd_i.note;
      end else if (cmd_i.free) begin
        note_q[cmd_i.idx] <= pva_pkg::NO_NOTE;
      end
    end
  end

  assign stat_o.active  = active_q;
  assign stat_o.gate    = gate_q;
  assign stat_o.rd_note = note_q[cmd_i.idx];

endmodule

### rtl/polyphonic_voice_allocator_core.sv
// Top level: event sequencer with serial voice scan and registered result word.
//
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+-------------
//  in_i    | in  | func, note_index, finished_voice                | valid/ready
//  out_o   | out | chosen_voice, stolen, gate/active masks, MIDI   | valid/ready
//
// Sequence: note on scans the voices in order and stops at the first free voice,
//   else steals; note off scans every voice; voice finished frees one voice; an
//   ignored event goes straight to the result state; the sequencer then returns
//   to idle before the next word is taken. The scan compares one voice per cycle.
// A new word is taken whenever the sequencer is idle, even while the previous
//   result still sits in the output register.
// Reset clears all voices, note slots to "no note", steal pointer to zero.
// A stalled output holds the sequencer in its final state until it drains.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pva_in_if.sink    in_i,
  pva_out_if.source out_o
);

  localparam int unsigned VC = pva_pkg::VOICE_COUNT;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ON   = 3'd1;  // scan for a free voice
  localparam logic [2:0] ST_OFF  = 3'd2;  // scan for matching notes
  localparam logic [2:0] ST_FIN  = 3'd3;  // free one voice
  localparam logic [2:0] ST_DONE = 3'd4;  // state settled, load result

  localparam pva_pkg::vidx_t LAST_IDX = pva_pkg::vidx_t'(VC - 1);

  logic [2:0] state_q, state_d;

  pva_pkg::vidx_t idx_q, idx_d;           // scan counter
  pva_pkg::vidx_t ptr_q, ptr_d;           // round-robin steal pointer
  pva_pkg::vidx_t chosen_q, chosen_d;
  logic           stolen_q, stolen_d;
  logic           mvalid_q, mvalid_d;

  // captured event
  logic [pva_pkg::FUNC_W-1:0]  func_q;
  pva_pkg::note_t              note_q;
  logic [pva_pkg::VOICE_W-1:0] fin_q;

  // output register
  logic                        out_valid_q;
  logic [pva_pkg::VOICE_W-1:0] o_chosen_q;
  logic                        o_stolen_q;
  pva_pkg::mask_t              o_gate_q, o_active_q;
  logic                        o_mvalid_q;
  logic [pva_pkg::STAT_W-1:0]  o_status_q;
  pva_pkg::key_t               o_key_q;
  logic [pva_pkg::VEL_W-1:0]   o_vel_q;

  pva_pkg::vf_cmd_t  vf_cmd;
  pva_pkg::vf_stat_t vf_stat;

  logic accept, load, last, hit, fin_ok, note_ok;
  pva_pkg::vidx_t fin_idx;

  pva_voice_file u_voice_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (vf_cmd),
    .stat_o (vf_stat)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load       = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign last       = (idx_q == LAST_IDX);
  assign note_ok    = (in_i.note_index < pva_pkg::NOTE_LIMIT);
  assign fin_ok     = ({2'b00, fin_q} < 6'(VC));
  assign fin_idx    = pva_pkg::vidx_t'(fin_q);

  // the one shared compare: free voice on note on, held note on note off
  always_comb begin
    if (state_q == ST_ON) begin
      hit = !vf_stat.active[idx_q];
    end else begin
      hit = vf_stat.active[idx_q] && (vf_stat.rd_note == note_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    ptr_d    = ptr_q;
    chosen_d = chosen_q;
    stolen_d = stolen_q;
    mvalid_d = mvalid_q;
    vf_cmd   = '{claim: 1'b0, free: 1'b0, gate_clr: 1'b0, idx: idx_q, note: note_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d    = '0;
          chosen_d = '0;
          stolen_d = 1'b0;
          mvalid_d = 1'b0;
          if (in_i.func == pva_pkg::FUNC_NOTE_ON && note_ok) begin
            state_d  = ST_ON;
            mvalid_d = 1'b1;
          end else if (in_i.func == pva_pkg::FUNC_NOTE_OFF && note_ok) begin
            state_d  = ST_OFF;
            mvalid_d = 1'b1;
          end else if (in_i.func == pva_pkg::FUNC_VOICE_FIN) begin
            state_d  = ST_FIN;
          end else begin
            state_d  = ST_DONE;   // out-of-range note or unused code
          end
        end
      end
      ST_ON: begin
        if (hit) begin
          vf_cmd.claim = 1'b1;
          chosen_d     = idx_q;
          state_d      = ST_DONE;
        end else if (last) begin
          // all busy: take the voice under the pointer
          vf_cmd.claim = 1'b1;
          vf_cmd.idx   = ptr_q;
          chosen_d     = ptr_q;
          stolen_d     = 1'b1;
          ptr_d        = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
          state_d      = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_OFF: begin
        vf_cmd.gate_clr = hit;
        if (last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FIN: begin
        vf_cmd.idx = fin_idx;
        if (fin_ok) begin
          vf_cmd.free = !vf_stat.gate[fin_idx];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    chosen_q <= chosen_d;
    stolen_q <= stolen_d;
    mvalid_q <= mvalid_d;
    if (accept) begin
      func_q <= in_i.func;
      note_q <= in_i.note_index;
      fin_q  <= in_i.finished_voice;
    end
  end

  // result word, built from the settled voice state
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_chosen_q <= pva_pkg::voice_t'(chosen_q);
      o_stolen_q <= stolen_q;
      o_gate_q   <= pva_pkg::mask_t'(vf_stat.gate[pva_pkg::MASK_USED-1:0]);
      o_active_q <= pva_pkg::mask_t'(vf_stat.active[pva_pkg::MASK_USED-1:0]);
      o_mvalid_q <= mvalid_q;
      if (!mvalid_q) begin
        o_status_q <= '0;
        o_key_q    <= '0;
        o_vel_q    <= '0;
      end else if (func_q == pva_pkg::FUNC_NOTE_ON) begin
        o_status_q <= pva_pkg::MIDI_NOTE_ON;
        o_key_q    <= pva_pkg::MIDI_TOP_KEY - pva_pkg::key_t'(note_q);
        o_vel_q    <= pva_pkg::MIDI_VEL_ON;
      end else begin
        o_status_q <= pva_pkg::MIDI_NOTE_OFF;
        o_key_q    <= pva_pkg::MIDI_TOP_KEY - pva_pkg::key_t'(note_q);
        o_vel_q    <= '0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.chosen_voice  = o_chosen_q;
  assign out_o.stolen        = o_stolen_q;
  assign out_o.gate_mask     = o_gate_q;
  assign out_o.active_mask   = o_active_q;
  assign out_o.midi_valid    = o_mvalid_q;
  assign out_o.midi_status   = o_status_q;
  assign out_o.midi_key      = o_key_q;
  assign out_o.midi_velocity = o_vel_q;

  // steal pointer never leaves the voice range
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LAST_IDX)
    else $error("steal pointer out of range");

  // a gated voice is always active
  a_gate_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vf_stat.gate & ~vf_stat.active) == '0)
    else $error("gate set on inactive voice");

  // a steal only happens with every voice busy, and leaves them all busy
  a_steal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && stolen_q) |-> (&vf_stat.active))
    else $error("steal reported with a free voice");

  // scan advances one voice per cycle until it hits or ends
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ON && !hit && !last) |=> (state_q == ST_ON && idx_q == $past(idx_q) + 1'b1))
    else $error("voice scan skipped");

endmodule

### dv/polyphonic_voice_allocator_core_test.sv
// Self-checking testbench for the voice allocator core: queued driver, checking monitor.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_core_test;

  // func code the block treats as a no-op
  localparam logic [pva_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // stretch of words with no idling on either side
  localparam int unsigned QUIET_LO = 500;
  localparam int unsigned QUIET_HI = 800;

  typedef struct {
    logic [pva_pkg::FUNC_W-1:0] func;
    pva_pkg::note_t             note;
    pva_pkg::voice_t            fin;
    bit                         drain;   // hold this word until every result is back
  } event_word_t;

  typedef struct packed {
    pva_pkg::voice_t             chosen_voice;
    logic                        stolen;
    pva_pkg::mask_t              gate_mask;
    pva_pkg::mask_t              active_mask;
    logic                        midi_valid;
    logic [pva_pkg::STAT_W-1:0]  midi_status;
    pva_pkg::key_t               midi_key;
    logic [pva_pkg::VEL_W-1:0]   midi_velocity;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  pva_in_if  ev_if ();
  pva_out_if res_if ();

  polyphonic_voice_allocator_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (ev_if),
    .out_o  (res_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  event_word_t   event_q[$];
  alloc_result_t alloc_results_q[$];
  event_word_t   cur_word;
  int unsigned   words_sent;
  int unsigned   words_checked;
  int unsigned   errors;

  // shadow voice file
  pva_pkg::vvec_t shadow_active;
  pva_pkg::vvec_t shadow_gate;
  pva_pkg::note_t shadow_note [pva_pkg::VOICE_COUNT];
  int unsigned    shadow_steal_ptr;

  // Applies one event to the shadow voice file and returns the result word it causes.
  function automatic alloc_result_t voice_step(event_word_t ev);
    alloc_result_t r;
    bit            found;
    int unsigned   pick;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    if (ev.func == pva_pkg::FUNC_NOTE_ON && ev.note < pva_pkg::NOTE_LIMIT) begin
      // lowest free voice first, else steal at the round-robin pointer
      for (int i = 0; i < pva_pkg::VOICE_COUNT; i++) begin
        if (!found && !shadow_active[i]) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        pick             = (shadow_steal_ptr >= pva_pkg::VOICE_COUNT) ? 0 : shadow_steal_ptr;
        shadow_steal_ptr = (pick + 1) % pva_pkg::VOICE_COUNT;
        r.stolen         = 1'b1;
      end
      shadow_note[pick]   = ev.note;
      shadow_active[pick] = 1'b1;
      shadow_gate[pick]   = 1'b1;
      r.chosen_voice      = pva_pkg::voice_t'(pick);
      r.midi_valid        = 1'b1;
      r.midi_status       = pva_pkg::MIDI_NOTE_ON;
      r.midi_key          = pva_pkg::MIDI_TOP_KEY - pva_pkg::key_t'(ev.note);
      r.midi_velocity     = pva_pkg::MIDI_VEL_ON;
    end else if (ev.func == pva_pkg::FUNC_NOTE_OFF && ev.note < pva_pkg::NOTE_LIMIT) begin
      for (int i = 0; i < pva_pkg::VOICE_COUNT; i++) begin
        if (shadow_active[i] && shadow_note[i] == ev.note) shadow_gate[i] = 1'b0;
      end
      r.midi_valid  = 1'b1;
      r.midi_status = pva_pkg::MIDI_NOTE_OFF;
      r.midi_key    = pva_pkg::MIDI_TOP_KEY - pva_pkg::key_t'(ev.note);
    end else if (ev.func == pva_pkg::FUNC_VOICE_FIN) begin
      // a gated voice keeps sounding
      if (ev.fin < pva_pkg::VOICE_COUNT && !shadow_gate[ev.fin]) begin
        shadow_active[ev.fin] = 1'b0;
        shadow_gate[ev.fin]   = 1'b0;
        shadow_note[ev.fin]   = pva_pkg::NO_NOTE;
      end
    end
    for (int i = 0; i < pva_pkg::MASK_USED; i++) begin
      r.gate_mask[i]   = shadow_gate[i];
      r.active_mask[i] = shadow_active[i];
    end
    return r;
  endfunction

  function automatic bit idle_roll(int unsigned count);
    if (count >= QUIET_LO && count < QUIET_HI) return 1'b0;
    return $urandom_range(99) < 30;
  endfunction

  task automatic push_word(logic [pva_pkg::FUNC_W-1:0] func, pva_pkg::note_t note,
                           pva_pkg::voice_t fin);
    event_word_t w;
    w.func  = func;
    w.note  = note;
    w.fin   = fin;
    w.drain = 1'b0;
    event_q.push_back(w);
  endtask

  // last queued word waits for the pipeline to empty
  task automatic mark_drain();
    event_word_t w;
    w       = event_q[$];
    w.drain = 1'b1;
    event_q[$] = w;
  endtask

  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      errors++;
    end
  endtask

  // Driver: presents queued words, predicts each one as it is accepted.
  always @(posedge clk) begin
    bit took;
    bit go;
    event_word_t nxt;
    if (rst_n) begin
      took = ev_if.valid && ev_if.ready;
      if (took) begin
        alloc_results_q.push_back(voice_step(cur_word));
        words_sent++;
      end
      if (!ev_if.valid || took) begin
        go = 1'b0;
        if (event_q.size() > 0) begin
          if (event_q[0].drain) begin
            // release the hold once nothing is in flight; the word goes out on a later pass
            if (!took && alloc_results_q.size() == 0) event_q[0].drain = 1'b0;
          end else if (!idle_roll(words_sent)) begin
            go = 1'b1;
          end
        end
        if (go) begin
          nxt                  = event_q.pop_front();
          cur_word             = nxt;
          ev_if.func           <= nxt.func;
          ev_if.note_index     <= nxt.note;
          ev_if.finished_voice <= nxt.fin;
          ev_if.valid          <= 1'b1;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (alloc_results_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual voice %0h gate %0h active %0h",
                   $time, res_if.chosen_voice, res_if.gate_mask, res_if.active_mask);
          errors++;
        end else begin
          want = alloc_results_q.pop_front();
          check_field("chosen_voice",  32'(want.chosen_voice),  32'(res_if.chosen_voice));
          check_field("stolen",        32'(want.stolen),        32'(res_if.stolen));
          check_field("gate_mask",     32'(want.gate_mask),     32'(res_if.gate_mask));
          check_field("active_mask",   32'(want.active_mask),   32'(res_if.active_mask));
          check_field("midi_valid",    32'(want.midi_valid),    32'(res_if.midi_valid));
          check_field("midi_status",   32'(want.midi_status),   32'(res_if.midi_status));
          check_field("midi_key",      32'(want.midi_key),      32'(res_if.midi_key));
          check_field("midi_velocity", 32'(want.midi_velocity), 32'(res_if.midi_velocity));
        end
        words_checked++;
      end
      res_if.ready <= !idle_roll(words_checked);
    end
  end

  initial begin
    int unsigned on_wt;
    int unsigned off_wt;
    int unsigned useful;
    int unsigned roll;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    ev_if.valid          = 1'b0;
    ev_if.func           = pva_pkg::FUNC_NOTE_ON;
    ev_if.note_index     = '0;
    ev_if.finished_voice = '0;
    res_if.ready         = 1'b0;
    words_sent           = 0;
    words_checked        = 0;
    errors               = 0;
    shadow_active        = '0;
    shadow_gate          = '0;
    shadow_steal_ptr     = 0;
    for (int i = 0; i < pva_pkg::VOICE_COUNT; i++) shadow_note[i] = pva_pkg::NO_NOTE;

    // fill every voice, one note each
    for (int n = 0; n < pva_pkg::NOTE_LIMIT; n++) begin
      push_word(pva_pkg::FUNC_NOTE_ON, pva_pkg::note_t'(n), pva_pkg::voice_t'(n));
    end
    // all busy: two steals in round-robin order
    push_word(pva_pkg::FUNC_NOTE_ON, 4'd3, 4'd0);
    push_word(pva_pkg::FUNC_NOTE_ON, 4'd7, 4'd0);
    // notes out of range and the unused func code
    push_word(pva_pkg::FUNC_NOTE_ON, 4'd13, 4'd1);
    push_word(pva_pkg::FUNC_NOTE_OFF, 4'd15, 4'd2);
    push_word(FUNC_UNUSED, 4'd5, 4'd15);
    // finished voice out of range
    push_word(pva_pkg::FUNC_VOICE_FIN, 4'd0, 4'd15);
    push_word(pva_pkg::FUNC_VOICE_FIN, 4'd0, 4'd13);
    // finished while still gated: stays
    push_word(pva_pkg::FUNC_VOICE_FIN, 4'd0, 4'd2);
    // release a single voice, then a note held by two voices
    push_word(pva_pkg::FUNC_NOTE_OFF, 4'd2, 4'd0);
    push_word(pva_pkg::FUNC_NOTE_OFF, 4'd3, 4'd0);
    // free it, then finish the already free voice
    push_word(pva_pkg::FUNC_VOICE_FIN, 4'd8, 4'd2);
    push_word(pva_pkg::FUNC_VOICE_FIN, 4'd8, 4'd2);
    push_word(pva_pkg::FUNC_NOTE_ON, 4'd12, 4'd0);
    push_word(pva_pkg::FUNC_VOICE_FIN, 4'd0, 4'd0);

    // random phases with shifting mix; the word before each phase waits for a drained pipeline
    for (int phase = 0; phase < 5; phase++) begin
      mark_drain();
      on_wt  = $urandom_range(55, 25);
      off_wt = $urandom_range(35, 15);
      useful = 0;
      while (useful < 250) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          case ($urandom_range(3))
            0: push_word(pva_pkg::FUNC_NOTE_ON, pva_pkg::note_t'($urandom_range(15, 13)),
                         pva_pkg::voice_t'($urandom));
            1: push_word(pva_pkg::FUNC_NOTE_OFF, pva_pkg::note_t'($urandom_range(15, 13)),
                         pva_pkg::voice_t'($urandom));
            2: push_word(FUNC_UNUSED, pva_pkg::note_t'($urandom), pva_pkg::voice_t'($urandom));
            default: push_word(pva_pkg::FUNC_VOICE_FIN, pva_pkg::note_t'($urandom),
                               pva_pkg::voice_t'($urandom_range(15, pva_pkg::VOICE_COUNT)));
          endcase
        end else begin
          useful++;
          roll = $urandom_range(99);
          if (roll < on_wt)
            push_word(pva_pkg::FUNC_NOTE_ON, pva_pkg::note_t'($urandom_range(12)),
                      pva_pkg::voice_t'($urandom));
          else if (roll < on_wt + off_wt)
            push_word(pva_pkg::FUNC_NOTE_OFF, pva_pkg::note_t'($urandom_range(12)),
                      pva_pkg::voice_t'($urandom));
          else
            push_word(pva_pkg::FUNC_VOICE_FIN, pva_pkg::note_t'($urandom),
                      pva_pkg::voice_t'($urandom_range(12)));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (event_q.size() > 0 || ev_if.valid || alloc_results_q.size() > 0) @(posedge clk);
    // room for any stray word still coming out
    repeat (4 * pva_pkg::VOICE_COUNT) @(posedge clk);
    if (alloc_results_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               alloc_results_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
